// ----- src/mf3_pkg.sv -----
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int OUT_DEPTH_DEF  = 8;

  localparam int CFG_WIDTH_BITS = 11;
  localparam int CFG_DATA_BITS  = 16;
  localparam int ROW_BITS       = 16;

  localparam int EDGE           = 2;

  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

endpackage

// ----- src/mf3_lbuf.sv -----
`timescale 1ns / 1ps

module mf3_lbuf #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COL_W      = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [COL_W-1:0]      rd_idx_i,
  input  logic [PIXEL_BITS-1:0] wr_pix_i,
  input  logic                  upd_en_i,
  input  logic [COL_W-1:0]      upd_idx_i,
  output logic [PIXEL_BITS-1:0] up_o,
  output logic [PIXEL_BITS-1:0] lo_o
);

  logic [PIXEL_BITS-1:0] mem_lo [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mem_up [MAX_WIDTH];

  logic [PIXEL_BITS-1:0] up_rd_q;
  logic [PIXEL_BITS-1:0] lo_rd_q;
  logic [PIXEL_BITS-1:0] fwd_data_q;
  logic                  fwd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      lo_rd_q        <= mem_lo[rd_idx_i];
      mem_lo[rd_idx_i] <= wr_pix_i;
    end
  end

  // upper row takes the old lower entry in the cycle after the read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_rd_q <= mem_up[rd_idx_i];
    end
    if (upd_en_i) begin
      mem_up[upd_idx_i] <= lo_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= lo_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= upd_en_i && (upd_idx_i == rd_idx_i);
    end
  end

  assign up_o = fwd_q ? fwd_data_q : up_rd_q;
  assign lo_o = lo_rd_q;

endmodule

// ----- src/mf3_median.sv -----
`timescale 1ns / 1ps

module mf3_median #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [2:0][PIXEL_BITS-1:0] col_i,
  input  logic                       sort_i,
  output logic [PIXEL_BITS-1:0]      median_o
);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // [column][row], column 2 newest
  logic [2:0][2:0][PIXEL_BITS-1:0] win_q;
  // [column][rank], rank 0 lowest
  logic [2:0][2:0][PIXEL_BITS-1:0] srt_q;
  logic [2:0][2:0][PIXEL_BITS-1:0] srt_d;

  pix_t lo_max;
  pix_t mid_med;
  pix_t hi_min;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= col_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      srt_d[k][0] = min2(min2(win_q[k][0], win_q[k][1]), win_q[k][2]);
      srt_d[k][1] = med3(win_q[k][0], win_q[k][1], win_q[k][2]);
      srt_d[k][2] = max2(max2(win_q[k][0], win_q[k][1]), win_q[k][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sort_i) begin
      srt_q <= srt_d;
    end
  end

  always_comb begin
    lo_max   = max2(max2(srt_q[0][0], srt_q[1][0]), srt_q[2][0]);
    mid_med  = med3(srt_q[0][1], srt_q[1][1], srt_q[2][1]);
    hi_min   = min2(min2(srt_q[0][2], srt_q[1][2]), srt_q[2][2]);
    median_o = med3(lo_max, mid_med, hi_min);
  end

endmodule

// ----- src/mf3_fifo.sv -----
`timescale 1ns / 1ps

module mf3_fifo #(
  parameter int DATA_W = 36,
  parameter int DEPTH  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  logic [DATA_W-1:0]          wdata0_i,
  input  logic [DATA_W-1:0]          wdata1_i,
  input  logic                       pop_i,
  output logic [DATA_W-1:0]          rdata_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q;
  logic [PtrW-1:0]   wr_d;
  logic [PtrW-1:0]   rd_q;
  logic [CntW-1:0]   count_q;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    case (push_n_i)
      2'd1:    wr_d = inc(wr_q);
      2'd2:    wr_d = inc(inc(wr_q));
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= wdata0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[inc(wr_q)] <= wdata1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      count_q <= count_q + CntW'(push_n_i) - CntW'(pop_i);
      if (pop_i) begin
        rd_q <= inc(rd_q);
      end
    end
  end

  assign rdata_o = mem_q[rd_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW+1)'(count_q) + (CntW+1)'(push_n_i) <= (CntW+1)'(DEPTH) + (CntW+1)'(pop_i))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("result queue underflow");

endmodule

// ----- src/median_filter_3x3_top.sv -----
`timescale 1ns / 1ps

// Streaming 3x3 median filter, one grey pixel per unstalled clock in raster order.
// The block counts row and column itself from frame_width and frame_height;
// pixels in the two outer rows and columns pass through unchanged, and an
// interior pixel comes out as the median of its original neighborhood once
// the pixel one row below and one column right has arrived, so one input
// beat gives zero, one or two result beats, median first. An input beat is
// accepted in every cycle as long as the result queue (OUT_DEPTH entries,
// counted together with the results still in the pipeline) has room for
// two more; a result is offered once the pixel causing it has passed the
// registers s1_q, s2_q and s3_q and the result queue. The two line buffers
// hold MAX_WIDTH entries each, take one read and one write per cycle and
// need no clearing after reset. Write configuration only between frames.

module median_filter_3x3_top import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               cfg_valid_i,
  output logic                                               cfg_ready_o,
  input  logic                                               cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]                           cfg_data_i,
  input  logic                                               in_valid_i,
  output logic                                               in_stall_o,
  input  logic [PIXEL_BITS-1:0]                              pixel_value_i,
  output logic                                               out_valid_o,
  input  logic                                               out_stall_i,
  output logic [ROW_BITS-1:0]                                out_row_o,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] out_col_o,
  output logic [PIXEL_BITS-1:0]                              out_value_o,
  output logic                                               last_of_run_o,
  output logic                                               frame_done_o
);

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CmpW = ((ColW > CFG_WIDTH_BITS) ? ColW : CFG_WIDTH_BITS) + 1;
  localparam int HgtW = ROW_BITS + 1;
  localparam int CntW = $clog2(OUT_DEPTH + 1);
  localparam int PendW = CntW + 3;

  typedef struct packed {
    logic                  med;
    logic                  brd;
    logic                  eof;
    logic [ROW_BITS-1:0]   row;
    logic [ColW-1:0]       col;
    logic [PIXEL_BITS-1:0] pix;
  } item_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]   row;
    logic [ColW-1:0]       col;
    logic [PIXEL_BITS-1:0] val;
    logic                  last;
    logic                  done;
  } res_t;

  logic [CFG_WIDTH_BITS-1:0] width_q;
  logic [ROW_BITS-1:0]       height_q;
  logic [ROW_BITS-1:0]       row_q;
  logic [ROW_BITS-1:0]       row_d;
  logic [ColW-1:0]           col_q;
  logic [ColW-1:0]           col_d;

  logic [CmpW-1:0] w_eff;
  logic [CmpW-1:0] w_raw;
  logic [CmpW-1:0] c_x;
  logic [HgtW-1:0] h_eff;
  logic [HgtW-1:0] r_x;

  logic  in_acc;
  logic  end_row;
  item_t item_d;
  item_t s1_q;
  item_t s2_q;
  item_t s3_q;
  logic  v1_q;
  logic  v2_q;
  logic  v3_q;

  logic [PIXEL_BITS-1:0]      up_pix;
  logic [PIXEL_BITS-1:0]      lo_pix;
  logic [PIXEL_BITS-1:0]      median;
  logic [2:0][PIXEL_BITS-1:0] new_col;

  res_t             med_res;
  res_t             brd_res;
  res_t             wr0;
  res_t             head;
  logic [1:0]       push_n;
  logic [CntW-1:0]  fifo_cnt;
  logic [PendW-1:0] pend;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_WIDTH_BITS'(WIDTH_RESET);
      height_q <= ROW_BITS'(HEIGHT_RESET);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[CFG_WIDTH_BITS-1:0];
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default:          width_q  <= width_q;
      endcase
    end
  end

  // classify the incoming position
  always_comb begin
    w_raw = CmpW'(width_q);
    if (w_raw == '0) begin
      w_eff = CmpW'(1);
    end else if (w_raw > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff = (height_q == '0) ? HgtW'(1) : HgtW'(height_q);
    c_x   = CmpW'(col_q);
    r_x   = HgtW'(row_q);

    end_row    = (c_x + CmpW'(1) >= w_eff);
    item_d.eof = end_row && (r_x + HgtW'(1) >= h_eff);
    item_d.med = (r_x >= HgtW'(EDGE + 1)) && (c_x >= CmpW'(EDGE + 1)) &&
                 (r_x + HgtW'(1) < h_eff) && (c_x + CmpW'(1) < w_eff);
    item_d.brd = (r_x < HgtW'(EDGE)) || (c_x < CmpW'(EDGE)) ||
                 (r_x + HgtW'(EDGE) >= h_eff) || (c_x + CmpW'(EDGE) >= w_eff);
    item_d.row = row_q;
    item_d.col = col_q;
    item_d.pix = pixel_value_i;

    col_d = end_row ? '0 : col_q + 1'b1;
    row_d = item_d.eof ? '0 : (end_row ? row_q + 1'b1 : row_q);
  end

  assign pend = PendW'(fifo_cnt) +
                PendW'(v1_q & s1_q.med) + PendW'(v1_q & s1_q.brd) +
                PendW'(v2_q & s2_q.med) + PendW'(v2_q & s2_q.brd) +
                PendW'(v3_q & s3_q.med) + PendW'(v3_q & s3_q.brd);

  assign in_stall_o = (pend + PendW'(2) > PendW'(OUT_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (in_acc) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= item_d;
    end
    if (v1_q) begin
      s2_q <= s1_q;
    end
    if (v2_q) begin
      s3_q <= s2_q;
    end
  end

  mf3_lbuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .COL_W      (ColW)
  ) u_lbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_idx_i  (col_q),
    .wr_pix_i  (pixel_value_i),
    .upd_en_i  (v1_q),
    .upd_idx_i (s1_q.col),
    .up_o      (up_pix),
    .lo_o      (lo_pix)
  );

  assign new_col = {s1_q.pix, lo_pix, up_pix};

  mf3_median #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median (
    .clk_i    (clk_i),
    .shift_i  (v1_q),
    .col_i    (new_col),
    .sort_i   (v2_q),
    .median_o (median)
  );

  always_comb begin
    med_res.row  = s3_q.row - 1'b1;
    med_res.col  = s3_q.col - 1'b1;
    med_res.val  = median;
    med_res.last = !s3_q.brd;
    med_res.done = 1'b0;

    brd_res.row  = s3_q.row;
    brd_res.col  = s3_q.col;
    brd_res.val  = s3_q.pix;
    brd_res.last = 1'b1;
    brd_res.done = s3_q.eof;

    wr0    = s3_q.med ? med_res : brd_res;
    push_n = v3_q ? (2'(s3_q.med) + 2'(s3_q.brd)) : 2'd0;
  end

  assign pop = out_valid_o && !out_stall_i;

  mf3_fifo #(
    .DATA_W ($bits(res_t)),
    .DEPTH  (OUT_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .wdata0_i (wr0),
    .wdata1_i (brd_res),
    .pop_i    (pop),
    .rdata_o  (head),
    .count_o  (fifo_cnt)
  );

  assign out_valid_o   = (fifo_cnt != '0);
  assign out_row_o     = head.row;
  assign out_col_o     = head.col;
  assign out_value_o   = head.val;
  assign last_of_run_o = head.last;
  assign frame_done_o  = head.done;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend <= PendW'(OUT_DEPTH))
    else $error("reserved results exceed queue depth");

  a_item_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q && (s1_q.col == $past(col_q)) && (s1_q.row == $past(row_q)))
    else $error("accepted pixel lost at first stage");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && item_d.eof) |=> (row_q == '0) && (col_q == '0))
    else $error("position not cleared at end of frame");

endmodule
